/* hdl/teleop_ema_watchdog_macros.svh */
// assertion macros shared by the teleop ema watchdog rtl
`ifndef TELEOP_EMA_WATCHDOG_MACROS_SVH
`define TELEOP_EMA_WATCHDOG_MACROS_SVH

// same-cycle implication
`define TEW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TEW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tew_pkg.sv */
// types, constants and the saturation helper function of the teleop ema watchdog
package tew_pkg;

   localparam int AXIS_BITS_DEFAULT  = 16;
   localparam int TIMER_BITS_DEFAULT = 16;

   localparam int VEL_BITS      = 20;
   localparam int CSR_BITS      = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int WIDE_BITS     = 48;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_LINEAR_GAIN     = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ANGULAR_GAIN    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SMOOTHING_ALPHA = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TIMEOUT_TICKS   = 3'd3;

   localparam logic [CSR_BITS-1:0] LINEAR_GAIN_RESET   = 16'd2048;
   localparam logic [CSR_BITS-1:0] ANGULAR_GAIN_RESET  = 16'd4096;
   localparam logic [CSR_BITS-1:0] ALPHA_RESET         = 16'd13107;
   localparam logic [CSR_BITS-1:0] TIMEOUT_RESET       = 16'd100;
   localparam logic [CSR_BITS-1:0] ALPHA_ONE           = 16'd32768;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic signed [WIDE_BITS-1:0] TGT_ROUND  = 48'sd2048;
   localparam int                          TGT_SHIFT  = 12;
   localparam logic signed [WIDE_BITS-1:0] STEP_ROUND = 48'sd16384;
   localparam int                          STEP_SHIFT = 15;

   localparam logic signed [WIDE_BITS-1:0] VEL_MAX_WIDE =
      WIDE_BITS'((64'sd1 <<< (VEL_BITS - 1)) - 64'sd1);
   localparam logic signed [WIDE_BITS-1:0] VEL_MIN_WIDE =
      WIDE_BITS'(-(64'sd1 <<< (VEL_BITS - 1)));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_GAIN,
      ST_TARGET,
      ST_MUL_ALPHA,
      ST_UPDATE,
      ST_DONE
   } tew_state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_SAMPLE,
      DP_TICK,
      DP_MUL_GAIN,
      DP_TARGET,
      DP_MUL_ALPHA,
      DP_UPDATE,
      DP_EMIT
   } tew_op_type;

   typedef struct packed {
      tew_op_type op;
      logic       ch;
   } tew_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic axes_valid;
      logic fire;
      logic rsp_free;
   } tew_status_type;

   function automatic logic signed [VEL_BITS-1:0] sat_vel(
      input logic signed [WIDE_BITS-1:0] v
   );
      logic signed [VEL_BITS-1:0] r;
      if (v > VEL_MAX_WIDE) begin
         r = VEL_MAX_WIDE[VEL_BITS-1:0];
      end else if (v < VEL_MIN_WIDE) begin
         r = VEL_MIN_WIDE[VEL_BITS-1:0];
      end else begin
         r = v[VEL_BITS-1:0];
      end
      return r;
   endfunction

endpackage

/* hdl/tew_req_if.sv */
// request channel: joystick samples and millisecond ticks
interface tew_req_if import tew_pkg::*; #(
   parameter int AXIS_BITS = AXIS_BITS_DEFAULT
) ();
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic signed [AXIS_BITS-1:0] axis_linear;
   logic signed [AXIS_BITS-1:0] axis_angular;
   logic                        axes_valid;

   modport source (output valid, opcode, axis_linear, axis_angular, axes_valid,
                   input ready);
   modport sink   (input valid, opcode, axis_linear, axis_angular, axes_valid,
                   output ready);
endinterface

/* hdl/tew_rsp_if.sv */
// response channel: velocity commands and halt flag
interface tew_rsp_if import tew_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VEL_BITS-1:0] linear_velocity;
   logic signed [VEL_BITS-1:0] angular_velocity;
   logic                       halt;

   modport source (output valid, linear_velocity, angular_velocity, halt,
                   input ready);
   modport sink   (input valid, linear_velocity, angular_velocity, halt,
                   output ready);
endinterface

/* hdl/tew_ctrl.sv */
// sequencer for decode, shared multiplier passes and result hand-off
`include "teleop_ema_watchdog_macros.svh"
module tew_ctrl import tew_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  tew_status_type status,
   output tew_cmd_type    cmd
);

   tew_state_type state_ff, state_in;
   logic          ch_ff, ch_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      req_ready = 1'b0;
      cmd.op    = DP_NONE;
      cmd.ch    = ch_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ch_in = 1'b0;
            if (status.is_tick) begin
               cmd.op   = DP_TICK;
               state_in = status.fire ? ST_DONE : ST_IDLE;
            end else begin
               cmd.op   = DP_SAMPLE;
               state_in = status.axes_valid ? ST_MUL_GAIN : ST_DONE;
            end
         end
         ST_MUL_GAIN: begin
            cmd.op   = DP_MUL_GAIN;
            state_in = ST_TARGET;
         end
         ST_TARGET: begin
            cmd.op   = DP_TARGET;
            state_in = ST_MUL_ALPHA;
         end
         ST_MUL_ALPHA: begin
            cmd.op   = DP_MUL_ALPHA;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.op = DP_UPDATE;
            if (ch_ff) begin
               state_in = ST_DONE;
            end else begin
               ch_in    = 1'b1;
               state_in = ST_MUL_GAIN;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.op   = DP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `TEW_ASSERT_NEXT(a_load_decodes, clock, reset, req_valid && req_ready, state_ff == ST_DECODE, "transfer not followed by decode")
   `TEW_ASSERT_NEXT(a_done_leaves, clock, reset, state_ff == ST_DONE && status.rsp_free, state_ff == ST_IDLE, "result stuck while output free")
   `TEW_ASSERT_IMPL(a_ch_switch, clock, reset, !$stable(ch_ff), $past(state_ff) == ST_UPDATE || $past(state_ff) == ST_DECODE, "channel select changed out of sequence")

endmodule

/* hdl/tew_dpath.sv */
// datapath: config registers, shared multiplier, averages, watchdog, output register
`include "teleop_ema_watchdog_macros.svh"
module tew_dpath import tew_pkg::*; #(
   parameter int AXIS_BITS  = AXIS_BITS_DEFAULT,
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [CSR_ADDR_BITS-1:0]    csr_index,
   input  logic [CSR_BITS-1:0]         csr_data,
   input  logic                        req_opcode,
   input  logic signed [AXIS_BITS-1:0] req_axis_linear,
   input  logic signed [AXIS_BITS-1:0] req_axis_angular,
   input  logic                        req_axes_valid,
   input  tew_cmd_type                 cmd,
   output tew_status_type              status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [VEL_BITS-1:0]  rsp_linear_velocity,
   output logic signed [VEL_BITS-1:0]  rsp_angular_velocity,
   output logic                        rsp_halt
);

   localparam int MulABits    = (AXIS_BITS > VEL_BITS + 1) ? AXIS_BITS : VEL_BITS + 1;
   localparam int MulBBits    = CSR_BITS + 1;
   localparam int ProdBits    = MulABits + MulBBits;
   localparam int ElapsedBits = TIMER_BITS + 1;
   localparam int CmpBits     = (ElapsedBits > CSR_BITS) ? ElapsedBits : CSR_BITS;

   logic [CSR_BITS-1:0] lin_gain_ff, ang_gain_ff, alpha_ff, timeout_ff;

   logic                        opcode_ff, axes_valid_ff;
   logic signed [AXIS_BITS-1:0] axis_lin_ff, axis_ang_ff;

   logic signed [VEL_BITS-1:0] s_lin_ff, s_ang_ff;
   logic [ElapsedBits-1:0]     elapsed_ff;
   logic                       link_active_ff;
   logic                       res_zero_ff, res_halt_ff;

   logic signed [ProdBits-1:0] prod_ff, prod_in;
   logic signed [VEL_BITS:0]   diff_ff, diff_in;

   logic                       rsp_valid_ff;
   logic signed [VEL_BITS-1:0] rsp_lin_ff, rsp_ang_ff;
   logic                       rsp_halt_ff;

   logic signed [AXIS_BITS-1:0] axis_sel;
   logic [CSR_BITS-1:0]         gain_sel, alpha_clamp;
   logic signed [VEL_BITS-1:0]  s_sel, target, s_new;
   logic signed [MulABits-1:0]  mul_a;
   logic signed [MulBBits-1:0]  mul_b;
   logic signed [WIDE_BITS-1:0] prod_wide, step_wide;
   logic [ElapsedBits-1:0]      elapsed_inc;
   logic                        fire;
   logic                        rsp_free;

   // operand selection and shared multiplier
   always_comb begin
      axis_sel    = cmd.ch ? axis_ang_ff : axis_lin_ff;
      gain_sel    = cmd.ch ? ang_gain_ff : lin_gain_ff;
      s_sel       = cmd.ch ? s_ang_ff : s_lin_ff;
      alpha_clamp = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      if (cmd.op == DP_MUL_ALPHA) begin
         mul_a = MulABits'(diff_ff);
         mul_b = signed'({1'b0, alpha_clamp});
      end else begin
         mul_a = MulABits'(axis_sel);
         mul_b = signed'({1'b0, gain_sel});
      end
      prod_in   = ProdBits'(mul_a * mul_b);
      prod_wide = WIDE_BITS'(prod_ff);
      target    = sat_vel((prod_wide + TGT_ROUND) >>> TGT_SHIFT);
      diff_in   = (VEL_BITS + 1)'(target) - (VEL_BITS + 1)'(s_sel);
      step_wide = (prod_wide + STEP_ROUND) >>> STEP_SHIFT;
      s_new     = sat_vel(step_wide + WIDE_BITS'(s_sel));
   end

   // watchdog
   always_comb begin
      elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + ElapsedBits'(1);
      fire        = link_active_ff && (CmpBits'(elapsed_inc) > CmpBits'(timeout_ff));
      rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign status.is_tick    = (opcode_ff == OP_TICK);
   assign status.axes_valid = axes_valid_ff;
   assign status.fire       = fire;
   assign status.rsp_free   = rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_gain_ff <= LINEAR_GAIN_RESET;
         ang_gain_ff <= ANGULAR_GAIN_RESET;
         alpha_ff    <= ALPHA_RESET;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LINEAR_GAIN:     lin_gain_ff <= csr_data;
            CSR_ANGULAR_GAIN:    ang_gain_ff <= csr_data;
            CSR_SMOOTHING_ALPHA: alpha_ff    <= csr_data;
            CSR_TIMEOUT_TICKS:   timeout_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_lin_ff       <= '0;
         s_ang_ff       <= '0;
         elapsed_ff     <= '0;
         link_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_ready && cmd.op != DP_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            DP_SAMPLE: begin
               link_active_ff <= 1'b1;
               elapsed_ff     <= '0;
            end
            DP_TICK: begin
               if (link_active_ff) begin
                  elapsed_ff <= elapsed_inc;
               end
               if (fire) begin
                  s_lin_ff       <= '0;
                  s_ang_ff       <= '0;
                  link_active_ff <= 1'b0;
               end
            end
            DP_UPDATE: begin
               if (cmd.ch) begin
                  s_ang_ff <= s_new;
               end else begin
                  s_lin_ff <= s_new;
               end
            end
            DP_EMIT: begin
               rsp_valid_ff <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD: begin
            opcode_ff     <= req_opcode;
            axis_lin_ff   <= req_axis_linear;
            axis_ang_ff   <= req_axis_angular;
            axes_valid_ff <= req_axes_valid;
         end
         DP_SAMPLE: begin
            res_zero_ff <= !axes_valid_ff;
            res_halt_ff <= 1'b0;
         end
         DP_TICK: begin
            res_zero_ff <= 1'b1;
            res_halt_ff <= 1'b1;
         end
         DP_MUL_GAIN, DP_MUL_ALPHA: begin
            prod_ff <= prod_in;
         end
         DP_TARGET: begin
            diff_ff <= diff_in;
         end
         DP_EMIT: begin
            rsp_lin_ff  <= res_zero_ff ? '0 : s_lin_ff;
            rsp_ang_ff  <= res_zero_ff ? '0 : s_ang_ff;
            rsp_halt_ff <= res_halt_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_linear_velocity  = rsp_lin_ff;
   assign rsp_angular_velocity = rsp_ang_ff;
   assign rsp_halt             = rsp_halt_ff;

   `TEW_ASSERT_IMPL(a_halt_zero, clock, reset, rsp_valid_ff && rsp_halt_ff, rsp_lin_ff == '0 && rsp_ang_ff == '0, "halt result with nonzero velocity")
   `TEW_ASSERT_NEXT(a_fire_clears, clock, reset, cmd.op == DP_TICK && fire, !link_active_ff && s_lin_ff == '0 && s_ang_ff == '0, "watchdog fire did not clear state")
   `TEW_ASSERT_NEXT(a_sample_arms, clock, reset, cmd.op == DP_SAMPLE, link_active_ff && elapsed_ff == '0, "sample did not rearm watchdog")

endmodule

/* hdl/teleop_ema_watchdog.sv */
// sample with axes: decode, gain, target, alpha and update per axis, then result
// two gain and two alpha passes share the one multiplier; next accepted after result
// sample without axes: decode, then a zero result; next accepted after it
// tick: next accepted after decode, or after a halt result when the watchdog fires
// a stalled result holds the next result, and the transfer after it, until it drains
// synchronous active-high reset: registers to defaults, averages zero, link inactive
module teleop_ema_watchdog import tew_pkg::*; #(
   parameter int AXIS_BITS  = AXIS_BITS_DEFAULT,
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]      csr_data,
   tew_req_if.sink                  req_chan,
   tew_rsp_if.source                rsp_chan
);

   tew_cmd_type    cmd;
   tew_status_type status;

   tew_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tew_dpath #(
      .AXIS_BITS  (AXIS_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_opcode           (req_chan.opcode),
      .req_axis_linear      (req_chan.axis_linear),
      .req_axis_angular     (req_chan.axis_angular),
      .req_axes_valid       (req_chan.axes_valid),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_linear_velocity  (rsp_chan.linear_velocity),
      .rsp_angular_velocity (rsp_chan.angular_velocity),
      .rsp_halt             (rsp_chan.halt)
   );

endmodule

/* bench/tb_teleop_ema_watchdog.sv */
// testbench of teleop_ema_watchdog: table and random joystick traffic checked against a predictor
module tb_teleop_ema_watchdog;
   import tew_pkg::*;

   localparam int AW = AXIS_BITS_DEFAULT;
   localparam int TW = TIMER_BITS_DEFAULT;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UNMAPPED = 3'd7;
   localparam int ROWS = 19;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 142;

   typedef struct packed {
      logic signed [VEL_BITS-1:0] lin;
      logic signed [VEL_BITS-1:0] ang;
      logic                       halt;
   } vel_cmd_type;

   typedef struct packed {
      logic              op;
      logic signed [AW-1:0] lin;
      logic signed [AW-1:0] ang;
      logic              av;
      logic              typed;
      logic              has;
      vel_cmd_type       want;
   } stim_row_type;

   localparam vel_cmd_type NO_CMD   = '0;
   localparam vel_cmd_type HALT_CMD = '{20'sd0, 20'sd0, 1'b1};

   logic clock = 1'b0;
   logic reset;
   logic csr_write;
   logic [CSR_ADDR_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0] csr_data;

   tew_req_if #(.AXIS_BITS(AW)) req_chan ();
   tew_rsp_if rsp_chan ();

   teleop_ema_watchdog #(.AXIS_BITS(AW), .TIMER_BITS(TW)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // predictor state and register copies
   logic [CSR_BITS-1:0] gain_lin, gain_ang, alpha_cfg, timeout_cfg;
   logic signed [VEL_BITS-1:0] avg_lin, avg_ang;
   logic [TW:0] ticks_since;
   bit link_up;

   vel_cmd_type expected_cmds[$];
   int error_count = 0;
   int live_items = 0;
   bit idle_en = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("tb_teleop_ema_watchdog: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic logic signed [VEL_BITS-1:0] clamp_vel(input longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (VEL_BITS - 1)) - 1;
      lo = -(longint'(1) <<< (VEL_BITS - 1));
      if (v > hi) begin
         return hi[VEL_BITS-1:0];
      end else if (v < lo) begin
         return lo[VEL_BITS-1:0];
      end
      return v[VEL_BITS-1:0];
   endfunction

   function automatic logic signed [VEL_BITS-1:0] ema_next(
      input logic signed [VEL_BITS-1:0] s,
      input logic signed [AW-1:0]       axis,
      input logic [CSR_BITS-1:0]        gain
   );
      longint a, tgt, stp;
      a = longint'((alpha_cfg > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg);
      tgt = clamp_vel((longint'(axis) * longint'(gain) + 2048) >>> 12);
      stp = (a * (tgt - longint'(s)) + 16384) >>> 15;
      return clamp_vel(longint'(s) + stp);
   endfunction

   // one input item through the watchdog and averages; returns 1 when it yields a command
   function automatic bit advance_teleop(
      input  logic                 op,
      input  logic signed [AW-1:0] lin,
      input  logic signed [AW-1:0] ang,
      input  logic                 av,
      output vel_cmd_type          cmd
   );
      cmd = NO_CMD;
      if (op == OP_SAMPLE) begin
         link_up = 1'b1;
         ticks_since = '0;
         if (av) begin
            avg_lin = ema_next(avg_lin, lin, gain_lin);
            avg_ang = ema_next(avg_ang, ang, gain_ang);
            cmd.lin = avg_lin;
            cmd.ang = avg_ang;
         end
         return 1'b1;
      end
      if (!link_up) begin
         return 1'b0;
      end
      if (ticks_since != '1) begin
         ticks_since++;
      end
      if (ticks_since > {1'b0, timeout_cfg}) begin
         avg_lin = '0;
         avg_ang = '0;
         link_up = 1'b0;
         cmd = HALT_CMD;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx, input logic [CSR_BITS-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      case (idx)
         CSR_LINEAR_GAIN: gain_lin = val;
         CSR_ANGULAR_GAIN: gain_ang = val;
         CSR_SMOOTHING_ALPHA: alpha_cfg = val;
         CSR_TIMEOUT_TICKS: timeout_cfg = val;
         default: ;
      endcase
   endtask

   task automatic set_config(
      input logic [CSR_BITS-1:0] lg,
      input logic [CSR_BITS-1:0] ag,
      input logic [CSR_BITS-1:0] al,
      input logic [CSR_BITS-1:0] to
   );
      write_reg(CSR_LINEAR_GAIN, lg);
      write_reg(CSR_ANGULAR_GAIN, ag);
      write_reg(CSR_SMOOTHING_ALPHA, al);
      write_reg(CSR_TIMEOUT_TICKS, to);
      write_reg(CSR_UNMAPPED, CSR_BITS'($urandom));
      csr_write <= 1'b0;
   endtask

   // wait until every command has come out and the block has gone quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic push_req(
      input logic                 op,
      input logic signed [AW-1:0] lin,
      input logic signed [AW-1:0] ang,
      input logic                 av,
      input logic                 typed,
      input logic                 typed_has,
      input vel_cmd_type          typed_cmd
   );
      vel_cmd_type cmd;
      bit has;
      while (idle_en && $urandom_range(0, 99) < 30) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.axis_linear <= lin;
      req_chan.axis_angular <= ang;
      req_chan.axes_valid <= av;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (op == OP_SAMPLE || link_up) begin
         live_items++;
      end
      has = advance_teleop(op, lin, ang, av, cmd);
      if (typed) begin
         has = typed_has;
         cmd = typed_cmd;
      end
      if (has) begin
         expected_cmds.push_back(cmd);
      end
   endtask

   function automatic logic signed [AW-1:0] joystick_value();
      case ($urandom_range(0, 7))
         0: return 16'sd32767;
         1: return -16'sd32768;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return AW'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_BITS-1:0] gain_value();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd4096;
         default: return CSR_BITS'($urandom);
      endcase
   endfunction

   // result side: random stalls and in-order comparison
   always @(posedge clock) begin : rsp_check
      vel_cmd_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_cmds.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_chan.linear_velocity !== want.lin) begin
                  report_mismatch($sformatf("linear_velocity %0d, expected %0d",
                     rsp_chan.linear_velocity, want.lin));
               end
               if (rsp_chan.angular_velocity !== want.ang) begin
                  report_mismatch($sformatf("angular_velocity %0d, expected %0d",
                     rsp_chan.angular_velocity, want.ang));
               end
               if (rsp_chan.halt !== want.halt) begin
                  report_mismatch($sformatf("halt %0b, expected %0b", rsp_chan.halt, want.halt));
               end
            end
         end
         rsp_chan.ready <= !(idle_en && $urandom_range(0, 99) < 30);
      end
   end

   initial begin
      stim_row_type stim_table [0:ROWS-1];
      int phase, kind, burst, target;

      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      req_chan.valid <= 1'b0;
      req_chan.opcode <= OP_SAMPLE;
      req_chan.axis_linear <= '0;
      req_chan.axis_angular <= '0;
      req_chan.axes_valid <= 1'b0;

      gain_lin = LINEAR_GAIN_RESET;
      gain_ang = ANGULAR_GAIN_RESET;
      alpha_cfg = ALPHA_RESET;
      timeout_cfg = TIMEOUT_RESET;
      avg_lin = '0;
      avg_ang = '0;
      ticks_since = '0;
      link_up = 1'b0;

      // unit gains and no smoothing: each valid sample comes back as its own axes
      stim_table = '{
         '{OP_TICK,   16'sd0,      16'sd0,      1'b0, 1'b1, 1'b0, NO_CMD},
         '{OP_SAMPLE, 16'sd32767,  -16'sd32768, 1'b0, 1'b1, 1'b1, NO_CMD},
         '{OP_SAMPLE, 16'sd32767,  -16'sd32768, 1'b1, 1'b1, 1'b1,
           '{20'sd32767, -20'sd32768, 1'b0}},
         '{OP_SAMPLE, -16'sd32768, 16'sd32767,  1'b1, 1'b1, 1'b1,
           '{-20'sd32768, 20'sd32767, 1'b0}},
         '{OP_SAMPLE, 16'sd0,      16'sd0,      1'b1, 1'b1, 1'b1, NO_CMD},
         '{OP_SAMPLE, -16'sd1,     16'sd1,      1'b1, 1'b1, 1'b1,
           '{-20'sd1, 20'sd1, 1'b0}},
         '{OP_TICK,   16'sd0,      16'sd0,      1'b0, 1'b1, 1'b0, NO_CMD},
         '{OP_TICK,   -16'sd1,     -16'sd1,     1'b1, 1'b1, 1'b0, NO_CMD},
         '{OP_TICK,   16'sd0,      16'sd0,      1'b0, 1'b1, 1'b1, HALT_CMD},
         '{OP_TICK,   16'sd0,      16'sd0,      1'b0, 1'b1, 1'b0, NO_CMD},
         '{OP_SAMPLE, 16'sd12345,  -16'sd23456, 1'b1, 1'b0, 1'b0, NO_CMD},
         '{OP_SAMPLE, -16'sd1,     -16'sd1,     1'b0, 1'b1, 1'b1, NO_CMD},
         '{OP_SAMPLE, 16'sd100,    -16'sd100,   1'b1, 1'b0, 1'b0, NO_CMD},
         '{OP_TICK,   16'sd0,      16'sd0,      1'b0, 1'b1, 1'b0, NO_CMD},
         '{OP_TICK,   16'sd0,      16'sd0,      1'b0, 1'b1, 1'b0, NO_CMD},
         '{OP_SAMPLE, 16'sd0,      16'sd0,      1'b0, 1'b1, 1'b1, NO_CMD},
         '{OP_TICK,   16'sd0,      16'sd0,      1'b0, 1'b1, 1'b0, NO_CMD},
         '{OP_TICK,   16'sd0,      16'sd0,      1'b0, 1'b1, 1'b0, NO_CMD},
         '{OP_TICK,   16'sd0,      16'sd0,      1'b0, 1'b1, 1'b1, HALT_CMD}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_config(16'd4096, 16'd4096, ALPHA_ONE, 16'd2);
      foreach (stim_table[i]) begin
         push_req(stim_table[i].op, stim_table[i].lin, stim_table[i].ang, stim_table[i].av,
                  stim_table[i].typed, stim_table[i].has, stim_table[i].want);
      end
      settle();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
            1: set_config(16'd0, 16'd0, 16'd0, 16'hFFFF);
            default: set_config(gain_value(), gain_value(),
               ($urandom_range(0, 3) == 0) ? ALPHA_ONE : CSR_BITS'($urandom_range(0, 32768)),
               CSR_BITS'($urandom_range(0, 20)));
         endcase
         idle_en = (phase != 3);
         target = live_items + ITEMS_PER_PHASE;
         while (live_items < target) begin
            if ($urandom_range(0, 99) < 2) begin
               settle();
            end
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
               push_req(OP_SAMPLE, joystick_value(), joystick_value(), 1'b1, 1'b0, 1'b0, NO_CMD);
            end else if (kind < 70) begin
               push_req(OP_SAMPLE, AW'($urandom), AW'($urandom), 1'b0, 1'b0, 1'b0, NO_CMD);
            end else begin
               burst = $urandom_range(1, (timeout_cfg > 28) ? 30 : int'(timeout_cfg) + 2);
               repeat (burst) begin
                  push_req(OP_TICK, AW'($urandom), AW'($urandom), 1'($urandom), 1'b0, 1'b0,
                           NO_CMD);
               end
            end
         end
         settle();
      end

      idle_en = 1'b1;
      settle();
      repeat (20) @(posedge clock);
      if (expected_cmds.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never came", expected_cmds.size()));
      end
      if (error_count == 0) begin
         $display("tb_teleop_ema_watchdog: done, clean");
      end else begin
         $display("tb_teleop_ema_watchdog: done, errors");
      end
      $finish;
   end

endmodule
